// File: rtl/mk_pkg.sv
// ----------------------------------------------------------------------------
// mk_pkg
// Shared types, constants and the character classifier for the Morse keyer.
// ----------------------------------------------------------------------------
package mk_pkg;

	localparam int TPU_W     = 24;
	localparam int DUR_W     = 26;
	localparam int MK_QDEPTH = 2;

	localparam logic [TPU_W-1:0] TPU_RESET = TPU_W'(1);

	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5a;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_NEWLINE = 8'h0a;

	localparam logic [5:0] DIGIT_BASE = 6'd26;

	typedef enum logic [1:0] {
		KIND_CODE,
		KIND_WORD,
		KIND_OTHER
	} kind_t;

	// bits are left aligned: bit 4 is the first element, 1 = dah
	typedef struct packed {
		kind_t      kind;
		logic [2:0] len;
		logic [4:0] bits;
	} mk_entry_t;

	// {len[2:0], bits[4:0]}, letters A-Z then digits 0-9
	localparam logic [7:0] MORSE_TABLE [0:35] = '{
		8'h41, 8'h88, 8'h8a, 8'h64, 8'h20, 8'h82, 8'h66, 8'h80, 8'h40,
		8'h87, 8'h65, 8'h84, 8'h43, 8'h42, 8'h67, 8'h86, 8'h8d, 8'h62,
		8'h60, 8'h21, 8'h61, 8'h81, 8'h63, 8'h89, 8'h8b, 8'h8c,
		8'hbf, 8'haf, 8'ha7, 8'ha3, 8'ha1, 8'ha0, 8'hb0, 8'hb8, 8'hbc, 8'hbe
	};

	function automatic mk_entry_t mk_classify(input logic [7:0] ch);
		logic [7:0] off;
		logic [7:0] code;
		mk_entry_t  e;
		off  = 8'd0;
		code = 8'd0;
		e    = '{kind: KIND_OTHER, len: 3'd0, bits: 5'd0};
		if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
			off  = ch - CH_UPPER_A;
			code = MORSE_TABLE[off[5:0]];
			e.kind = KIND_CODE;
		end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
			off  = ch - CH_ZERO;
			code = MORSE_TABLE[off[5:0] + DIGIT_BASE];
			e.kind = KIND_CODE;
		end else if (ch == CH_SPACE || ch == CH_NEWLINE) begin
			e.kind = KIND_WORD;
		end
		e.len  = code[7:5];
		e.bits = code[4:0] << (3'd5 - code[7:5]);
		return e;
	endfunction

endpackage

// File: rtl/morse_keyer.sv
// ----------------------------------------------------------------------------
// morse_keyer
// International Morse keyer: one ASCII character in, a run of timed LED
// segments out.
// ----------------------------------------------------------------------------
//  channel  signals                               direction
//  in       in_valid/in_ready, character          into block
//  out      out_valid/out_ready, led_on,          out of block
//           duration_ticks, last
//  cfg      psel/penable/pwrite/paddr/pwdata/     APB, ticks_per_unit at 0
//           prdata/pready
//
//  a code of n elements is loaded, then sent as 2n segments, one per cycle
//  unless stalled; space, newline and other characters give one segment
//  the front register and the queue take new characters while the back end
//  is busy or its output register is stalled
//  reset clears all control state and sets ticks_per_unit to 1
// ----------------------------------------------------------------------------
module morse_keyer import mk_pkg::*; #(
	parameter int QUEUE_DEPTH = MK_QDEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       character,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             led_on,
	output logic [DUR_W-1:0] duration_ticks,
	output logic             last,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [2:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic             tpu_sel;
	logic [TPU_W-1:0] tpu_q;
	logic             push;
	logic             pop;
	logic             full;
	logic             empty;
	mk_entry_t        push_entry;
	mk_entry_t        head;

	assign pready  = 1'b1;
	assign tpu_sel = (paddr[2] == 1'b0);
	assign prdata  = tpu_sel ? 32'(tpu_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpu_q <= TPU_RESET;
		end else if (psel && penable && pwrite && tpu_sel) begin
			tpu_q <= pwdata[TPU_W-1:0];
		end
	end

	mk_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.character  (character),
		.push       (push),
		.push_entry (push_entry),
		.full       (full)
	);

	mk_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.full       (full),
		.empty      (empty)
	);

	mk_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (head),
		.empty          (empty),
		.pop            (pop),
		.ticks_per_unit (tpu_q),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.led_on         (led_on),
		.duration_ticks (duration_ticks),
		.last           (last)
	);

`ifndef SYNTHESIS
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("push into full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("pop from empty queue");

	a_last_is_dark: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> !led_on)
		else $error("lit segment marked last");

	a_lit_length: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && led_on |-> duration_ticks == DUR_W'(tpu_q) ||
			duration_ticks == DUR_W'(tpu_q) + (DUR_W'(tpu_q) << 1))
		else $error("lit segment is neither a dit nor a dah");
`endif

endmodule

// File: rtl/mk_front.sv
// ----------------------------------------------------------------------------
// mk_front
// Takes characters in, registers them and classifies them into queue entries.
// ----------------------------------------------------------------------------
module mk_front import mk_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  logic [7:0] character,
	output logic      push,
	output mk_entry_t push_entry,
	input  logic      full
);

	logic       valid_s1;
	logic [7:0] char_s1;

	assign push       = valid_s1 && !full;
	assign push_entry = mk_classify(char_s1);
	assign in_ready   = !valid_s1 || !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1 <= character;
		end
	end

endmodule

// File: rtl/mk_fifo.sv
// ----------------------------------------------------------------------------
// mk_fifo
// Short queue of classified characters between front and back.
// ----------------------------------------------------------------------------
module mk_fifo import mk_pkg::*; #(
	parameter int DEPTH = MK_QDEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  mk_entry_t push_entry,
	input  logic      pop,
	output mk_entry_t head,
	output logic      full,
	output logic      empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

	mk_entry_t        mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign head  = mem_q[rd_ptr_q];
	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

// File: rtl/mk_back.sv
// ----------------------------------------------------------------------------
// mk_back
// Walks one queued character element by element and emits LED segments.
// ----------------------------------------------------------------------------
module mk_back import mk_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  mk_entry_t        head,
	input  logic             empty,
	output logic             pop,
	input  logic [TPU_W-1:0] ticks_per_unit,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             led_on,
	output logic [DUR_W-1:0] duration_ticks,
	output logic             last
);

	typedef enum logic [1:0] {
		UNITS_1,
		UNITS_3,
		UNITS_4
	} units_t;

	logic             busy_q;
	kind_t            kind_q;
	logic [2:0]       rem_q;
	logic [4:0]       sh_q;
	logic             gap_q;
	logic             out_valid_q;

	logic             advance;
	logic             seg_lit;
	logic             seg_last;
	logic             seg_done;
	units_t           seg_units;
	logic [DUR_W-1:0] tpu_x1;
	logic [DUR_W-1:0] seg_dur;

	assign pop       = !busy_q && !empty;
	assign advance   = busy_q && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	always_comb begin
		seg_lit   = 1'b0;
		seg_last  = 1'b1;
		seg_done  = 1'b1;
		seg_units = UNITS_3;
		case (kind_q)
			KIND_CODE: begin
				if (!gap_q) begin
					seg_lit   = 1'b1;
					seg_last  = 1'b0;
					seg_done  = 1'b0;
					seg_units = sh_q[4] ? UNITS_3 : UNITS_1;
				end else begin
					// last element closes with the letter gap
					seg_last  = (rem_q == 3'd1);
					seg_done  = (rem_q == 3'd1);
					seg_units = (rem_q == 3'd1) ? UNITS_3 : UNITS_1;
				end
			end
			KIND_WORD: seg_units = UNITS_4;
			default:   seg_units = UNITS_3;
		endcase
	end

	assign tpu_x1 = DUR_W'(ticks_per_unit);

	always_comb begin
		case (seg_units)
			UNITS_1: seg_dur = tpu_x1;
			UNITS_3: seg_dur = tpu_x1 + (tpu_x1 << 1);
			UNITS_4: seg_dur = tpu_x1 << 2;
			default: seg_dur = tpu_x1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
			gap_q       <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				gap_q  <= 1'b0;
			end else if (advance) begin
				if (seg_done) begin
					busy_q <= 1'b0;
				end
				gap_q <= !gap_q;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q <= head.kind;
			rem_q  <= head.len;
			sh_q   <= head.bits;
		end else if (advance && gap_q) begin
			rem_q <= rem_q - 1'b1;
			sh_q  <= sh_q << 1;
		end
		if (advance) begin
			led_on         <= seg_lit;
			duration_ticks <= seg_dur;
			last           <= seg_last;
		end
	end

endmodule
